FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NBPT_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NBPT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/nbpt_pkg.sv
`default_nettype none

package nbpt_pkg;

	// Model geometry and counter widths.
	localparam int MAX_WIDTH   = 32;
	localparam int NUM_CLASSES = 16;
	localparam int COUNT_BITS  = 16;
	localparam int FRAC_BITS   = 16;

	// Field widths of the request and the registers.
	localparam int CLASS_BITS = 4;
	localparam int POS_BITS   = 5;
	localparam int K_BITS     = 8;
	localparam int WREG_BITS  = 6;
	localparam int DIST_BITS  = 5;

	// Shaded count store: one word per class, row and column.
	localparam int ADDR_BITS = CLASS_BITS + 2 * POS_BITS;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	// Divider widths: operands fit one bit above a count, remainder one more.
	localparam int RATIO_BITS = COUNT_BITS + 1;
	localparam int REM_BITS   = RATIO_BITS + 1;
	localparam int PROB_BITS  = FRAC_BITS + 1;
	localparam int STEP_BITS  = $clog2(FRAC_BITS);
	localparam int MUL_BITS   = DIST_BITS + K_BITS;

	localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
	localparam logic [DIST_BITS-1:0]  DIST_MAX = '1;
	localparam logic [PROB_BITS-1:0]  PROB_ONE = PROB_BITS'(1) << FRAC_BITS;

	// Register reset values.
	localparam logic [K_BITS-1:0]    K_RESET     = K_BITS'(1);
	localparam logic [WREG_BITS-1:0] WIDTH_RESET = WREG_BITS'(28);

	// Register indexes on the configuration port.
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTHING_K = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH = 1'd1;

	// Request functions.
	localparam logic [1:0] FUNC_TRAIN = 2'd0;
	localparam logic [1:0] FUNC_PIXEL = 2'd1;
	localparam logic [1:0] FUNC_CLASS = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_UNSEEN  = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic rd;
		logic train_wr;
		logic prep;
		logic div_init;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic req_train;
		logic req_query;
		logic train;
		logic skip;
		logic div_last;
	} dp_status_t;

	// Counter increment that holds at the maximum.
	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nbpt_ram.sv
`default_nettype none

module nbpt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/nbpt_ctrl.sv
`default_nettype none

module nbpt_ctrl
	import nbpt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dp_status_t dp_st,
	output ctrl_cmd_t       cmd,
	output logic            busy
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_RD    = 8'b0000_0100,
		S_WR    = 8'b0000_1000,
		S_PREP  = 8'b0001_0000,
		S_CHK   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (dp_st.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (dp_st.req_train || dp_st.req_query) begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = dp_st.train ? S_WR : S_PREP;
			end
			S_WR: begin
				cmd.train_wr = 1'b1;
				state_d      = S_IDLE;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				cmd.div_init = 1'b1;
				state_d      = dp_st.skip ? S_FIN : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (dp_st.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/nbpt_datapath.sv
`default_nettype none

module nbpt_datapath
	import nbpt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctrl_cmd_t               cmd,
	output dp_status_t                   dp_st,
	input  wire logic                    cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [K_BITS-1:0]       cfg_wdata,
	input  wire logic [1:0]              func,
	input  wire logic [CLASS_BITS-1:0]   class_label,
	input  wire logic [POS_BITS-1:0]     pixel_row,
	input  wire logic [POS_BITS-1:0]     pixel_col,
	input  wire logic                    shaded,
	input  wire logic                    image_end,
	output logic      [PROB_BITS-1:0]    probability,
	output logic      [1:0]              status,
	output logic                         done
);

	// Configuration registers.
	logic [K_BITS-1:0]    k_q;
	logic [WREG_BITS-1:0] width_q;

	// Latched request.
	logic [1:0]            func_q;
	logic [CLASS_BITS-1:0] cls_q;
	logic [POS_BITS-1:0]   row_q;
	logic [POS_BITS-1:0]   col_q;
	logic                  shd_q;
	logic                  last_q;

	// Class statistics.
	logic [COUNT_BITS-1:0] cc_q [NUM_CLASSES];
	logic [COUNT_BITS-1:0] total_q;
	logic [DIST_BITS-1:0]  distinct_q;

	// Shaded count store and clearing counter.
	logic [ADDR_BITS-1:0]  clr_cnt_q;
	logic [ADDR_BITS-1:0]  addr;
	logic [COUNT_BITS-1:0] rdata;
	logic                  mem_we;
	logic [ADDR_BITS-1:0]  mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	// Ratio operands and divider.
	logic [MUL_BITS-1:0]   mul_q;
	logic [RATIO_BITS-1:0] num_q;
	logic [RATIO_BITS-1:0] den_q;
	logic [1:0]            flt_q;
	logic                  sat_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [FRAC_BITS-1:0]  quo_q;
	logic [STEP_BITS-1:0]  step_q;

	logic [WREG_BITS-1:0]  w_use;
	logic                  in_pos;
	logic                  cls_ok_in;
	logic [COUNT_BITS-1:0] cc_sel;
	logic [COUNT_BITS-1:0] v_sel;
	logic [RATIO_BITS-1:0] num_d;
	logic [RATIO_BITS-1:0] den_d;
	logic [1:0]            flt_d;
	logic [REM_BITS-1:0]   rem_sh;
	logic                  rem_ge;
	logic [REM_BITS:0]     rem_dbl;
	logic [PROB_BITS-1:0]  rounded;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= K_RESET;
			width_q <= WIDTH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SMOOTHING_K: k_q     <= cfg_wdata;
				REG_IMAGE_WIDTH: width_q <= cfg_wdata[WREG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Latch the accepted request.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			cls_q  <= class_label;
			row_q  <= pixel_row;
			col_q  <= pixel_col;
			shd_q  <= shaded;
			last_q <= image_end;
		end
	end

	// Decode of the request on the ports and of the latched one.
	assign cls_ok_in = ({1'b0, class_label} < (CLASS_BITS + 1)'(NUM_CLASSES));
	assign w_use     = (width_q > WREG_BITS'(MAX_WIDTH)) ? WREG_BITS'(MAX_WIDTH) : width_q;
	assign in_pos    = ({1'b0, row_q} < w_use) && ({1'b0, col_q} < w_use);
	assign cc_sel    = cc_q[cls_q];
	assign addr      = {cls_q, row_q, col_q};

	assign dp_st.req_train = (func == FUNC_TRAIN) && cls_ok_in;
	assign dp_st.req_query = (func == FUNC_PIXEL) || (func == FUNC_CLASS);
	assign dp_st.train     = (func_q == FUNC_TRAIN);
	assign dp_st.clear_last = (clr_cnt_q == '1);

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= clr_cnt_q + ADDR_BITS'(1);
		end
	end

	// Store writes: zeros while clearing, else the incremented shaded count.
	assign mem_we    = cmd.clear_wr || (cmd.train_wr && in_pos && shd_q);
	assign mem_waddr = cmd.clear_wr ? clr_cnt_q : addr;
	assign mem_wdata = cmd.clear_wr ? '0 : sat_inc(rdata);

	nbpt_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MEM_DEPTH)
	) u_shaded_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (cmd.rd),
		.raddr(addr),
		.rdata(rdata)
	);

	// Image counting on the last pixel of a training image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cc_q[i] <= '0;
			end
			total_q    <= '0;
			distinct_q <= '0;
		end else if (cmd.train_wr && last_q) begin
			if ((cc_sel == '0) && (distinct_q != DIST_MAX)) begin
				distinct_q <= distinct_q + DIST_BITS'(1);
			end
			cc_q[cls_q] <= sat_inc(cc_sel);
			total_q     <= sat_inc(total_q);
		end
	end

	// Class weight term V*k, ready before the operands are formed.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			mul_q <= MUL_BITS'(distinct_q) * MUL_BITS'(k_q);
		end
	end

	// Operands of the ratio and the fault code.
	always_comb begin
		if (shd_q) begin
			v_sel = rdata;
		end else if (rdata >= cc_sel) begin
			v_sel = '0;
		end else begin
			v_sel = cc_sel - rdata;
		end
		if (func_q == FUNC_PIXEL) begin
			num_d = RATIO_BITS'(k_q) + RATIO_BITS'(v_sel);
			den_d = RATIO_BITS'({k_q, 1'b0}) + RATIO_BITS'(cc_sel);
		end else begin
			num_d = RATIO_BITS'(k_q) + RATIO_BITS'(cc_sel);
			den_d = RATIO_BITS'(mul_q) + RATIO_BITS'(total_q);
		end
		if ((func_q == FUNC_PIXEL) && !in_pos) begin
			flt_d = STATUS_OUTSIDE;
		end else if (cc_sel == '0) begin
			flt_d = STATUS_UNSEEN;
		end else begin
			flt_d = STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			num_q <= num_d;
			den_q <= den_d;
			flt_q <= flt_d;
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign rem_sh = {rem_q[REM_BITS-2:0], 1'b0};
	assign rem_ge = (rem_sh >= REM_BITS'(den_q));

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= REM_BITS'(num_q);
			quo_q  <= '0;
			step_q <= '0;
			sat_q  <= (num_q >= den_q);
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? (rem_sh - REM_BITS'(den_q)) : rem_sh;
			quo_q  <= {quo_q[FRAC_BITS-2:0], rem_ge};
			step_q <= step_q + STEP_BITS'(1);
		end
	end

	assign dp_st.skip     = (flt_q != STATUS_OK) || (num_q >= den_q);
	assign dp_st.div_last = (step_q == STEP_BITS'(FRAC_BITS - 1));

	// Round to nearest, ties up, from the final remainder.
	assign rem_dbl = {rem_q, 1'b0};
	assign rounded = PROB_BITS'(quo_q)
		+ PROB_BITS'(rem_dbl >= (REM_BITS + 1)'(den_q));

	// Result register and strobe.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status <= flt_q;
			if (flt_q != STATUS_OK) begin
				probability <= '0;
			end else if (sat_q) begin
				probability <= PROB_ONE;
			end else begin
				probability <= rounded;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/naive_bayes_pixel_trainer_unit.sv
`default_nettype none

// Bernoulli naive Bayes trainer with Laplace smoothing. After reset the unit
// clears all 16384 words of its shaded count store, one word a cycle, and
// holds busy high meanwhile; configuration writes are taken at any time. A
// request is taken when start is high, busy is low and func is a known
// function. A training pixel keeps the unit busy through a read state and a
// write state, the read-modify-write through the single read port of the
// count store. A query keeps it busy through the read, prepare, check, divide
// and finish states; the restoring divider yields one quotient bit per cycle.
// A query that faults or that saturates at one skips the divider. Each
// result appears for exactly one cycle with done high, in the first cycle in
// which busy is low again, and must be taken then: the receiver cannot stall
// the unit. A new request may be accepted in that same cycle.

`include "assert_macros.svh"

module naive_bayes_pixel_trainer_unit
	import nbpt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [K_BITS-1:0]       cfg_wdata,
	input  wire logic [1:0]              func,
	input  wire logic [CLASS_BITS-1:0]   class_label,
	input  wire logic [POS_BITS-1:0]     pixel_row,
	input  wire logic [POS_BITS-1:0]     pixel_col,
	input  wire logic                    shaded,
	input  wire logic                    image_end,
	output logic      [PROB_BITS-1:0]    probability,
	output logic      [1:0]              status,
	output logic                         done
);

	ctrl_cmd_t  cmd;
	dp_status_t dp_st;

	// Sequencing.
	nbpt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.dp_st (dp_st),
		.cmd   (cmd),
		.busy  (busy)
	);

	// Counters, count store and divider.
	nbpt_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dp_st      (dp_st),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.func       (func),
		.class_label(class_label),
		.pixel_row  (pixel_row),
		.pixel_col  (pixel_col),
		.shaded     (shaded),
		.image_end  (image_end),
		.probability(probability),
		.status     (status),
		.done       (done)
	);

	// A faulted result carries a zero probability.
	`NBPT_ASSERT_IMPLY(a_fault_zero, clk, arst_n, done && (status != STATUS_OK), probability == '0, "faulted result with nonzero probability")

	// A probability never exceeds one.
	`NBPT_ASSERT_IMPLY(a_prob_le_one, clk, arst_n, done, probability <= PROB_ONE, "probability above one")

	// A result only follows a cycle in which the unit was working.
	`NBPT_ASSERT_IMPLY(a_done_after_busy, clk, arst_n, done, $past(busy), "result without preceding work")

	// An accepted request never coincides with a result in the next cycle.
	`NBPT_ASSERT_NEXT(a_no_done_after_accept, clk, arst_n, start && !busy, !done, "result right after acceptance")

endmodule

`default_nettype wire
